// ===== rtl/tfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfpc_pkg
// shared types, widths, reset values and arithmetic helpers of the
// four-point touch calibration block
// ----------------------------------------------------------------------------
package tfpc_pkg;

  localparam int RAW_W   = 12;
  localparam int REG_W   = 2 * RAW_W;
  localparam int EO_W    = 8;
  localparam int RES_W   = 12;
  localparam int COORD_W = 11;
  localparam int SPAN_W  = 13;
  localparam int DEN_W   = 13;
  localparam int DVSM_W  = 12;
  localparam int MAG_W   = 24;
  localparam int PROD_W  = 25;
  localparam int CNUM_W  = 28;
  localparam int OFS_W   = 28;
  localparam int V_W     = OFS_W + 1;
  localparam int DIV_STG = MAG_W;
  localparam int NSTG    = DIV_STG + 4;
  localparam int CFG_AW  = 3;
  localparam int OUT_DW  = 24;

  localparam logic [RES_W-1:0] LIM_MAX = 12'd2048;

  localparam logic [REG_W-1:0] UL_RST = 24'd819400;
  localparam logic [REG_W-1:0] UR_RST = 24'd15954120;
  localparam logic [REG_W-1:0] LR_RST = 24'd15957815;
  localparam logic [REG_W-1:0] LL_RST = 24'd823095;
  localparam logic [EO_W-1:0]  EO_RST = 8'd20;
  localparam logic [RES_W-1:0] HR_RST = 12'd480;
  localparam logic [RES_W-1:0] VR_RST = 12'd320;

  typedef enum logic [CFG_AW-1:0] {
    REG_UL   = 3'd0,
    REG_UR   = 3'd1,
    REG_LR   = 3'd2,
    REG_LL   = 3'd3,
    REG_EO   = 3'd4,
    REG_HRES = 3'd5,
    REG_VRES = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_WAIT,
    ST_FIN
  } coef_state_t;

  typedef struct packed {
    logic signed [SPAN_W-1:0] span;
    logic [DVSM_W-1:0]        dmag;
    logic                     dneg;
    logic signed [OFS_W-1:0]  ofs;
    logic                     err;
    logic [RES_W-1:0]         lim;
  } axis_coef_t;

  typedef struct packed {
    axis_coef_t ax;
    axis_coef_t ay;
    logic       busy;
  } coef_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [DVSM_W:0] div_step(input logic [DVSM_W-1:0] rem,
                                               input logic inbit,
                                               input logic [DVSM_W-1:0] dm);
    logic [DVSM_W:0] sh;
    logic [DVSM_W:0] df;
    sh = {rem, inbit};
    df = sh - {1'b0, dm};
    if (sh >= {1'b0, dm}) begin
      return {1'b1, df[DVSM_W-1:0]};
    end else begin
      return {1'b0, sh[DVSM_W-1:0]};
    end
  endfunction

  // halving with truncation toward zero
  function automatic logic signed [DEN_W-1:0] half14(input logic signed [DEN_W:0] x);
    logic signed [DEN_W:0] t;
    t = x + {{DEN_W{1'b0}}, x[DEN_W]};
    return t[DEN_W:1];
  endfunction

  function automatic logic signed [OFS_W-1:0] half29(input logic signed [OFS_W:0] x);
    logic signed [OFS_W:0] t;
    t = x + {{OFS_W{1'b0}}, x[OFS_W]};
    return t[OFS_W:1];
  endfunction

endpackage

// ===== rtl/tfpc_sdiv.sv =====
// ----------------------------------------------------------------------------
// tfpc_sdiv
// bit-serial signed divider, truncating toward zero, one quotient bit a cycle
// ----------------------------------------------------------------------------
module tfpc_sdiv
  import tfpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [CNUM_W-1:0] num,
  input  logic signed [DEN_W-1:0]  dvs,
  output logic                     done,
  output logic signed [CNUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(CNUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVSM_W-1:0] rem_r;
  logic [CNUM_W-1:0] q_r;
  logic [DVSM_W-1:0] dm_r;
  logic              neg_r;

  logic [CNUM_W-1:0] nmag;
  logic [DEN_W-1:0]  dfull;
  logic [DVSM_W:0]   stp;
  logic [DVSM_W-1:0] rem_nxt;
  logic [CNUM_W-1:0] q_nxt;

  always_comb begin
    nmag    = num[CNUM_W-1] ? CNUM_W'(-num) : CNUM_W'(num);
    dfull   = dvs[DEN_W-1] ? DEN_W'(-dvs) : DEN_W'(dvs);
    stp     = div_step(rem_r, q_r[CNUM_W-1], dm_r);
    rem_nxt = stp[DVSM_W-1:0];
    q_nxt   = {q_r[CNUM_W-2:0], stp[DVSM_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CNUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= nmag;
      dm_r  <= dfull[DVSM_W-1:0];
      neg_r <= num[CNUM_W-1] ^ dvs[DEN_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// ===== rtl/tfpc_coef.sv =====
// ----------------------------------------------------------------------------
// tfpc_coef
// calibration registers and the sequencer that derives spans, divisors and
// intercepts per axis with one shared serial divider
// ----------------------------------------------------------------------------
module tfpc_coef
  import tfpc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata,
  output coef_t             coef
);

  logic [REG_W-1:0] ul_r, ur_r, lr_r, ll_r;
  logic [EO_W-1:0]  eo_r;
  logic [RES_W-1:0] hres_r, vres_r;

  coef_state_t state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        start;

  logic signed [CNUM_W-1:0] num_r;
  logic signed [DEN_W-1:0]  dvs_r;
  logic signed [OFS_W-1:0]  c_r [4];
  axis_coef_t               ax_r, ay_r;

  logic                     div_done;
  logic signed [CNUM_W-1:0] div_quo;

  logic [RAW_W-1:0]         ulx, urx, lrx, llx, uly, ury, lry, lly;
  logic signed [DEN_W-1:0]  d1x, d2x, d1y, d2y, dx, dy;
  logic signed [SPAN_W-1:0] spx, spy, span_sel;
  logic [RAW_W:0]           sax, sbx, say, sby, sum_sel;
  logic signed [DEN_W-1:0]  dvs_sel;
  logic signed [CNUM_W-1:0] op_a, op_b, num_nxt;
  logic signed [OFS_W:0]    cdiff;
  logic [RES_W-1:0]         full_sel;
  axis_coef_t               ax_nxt, ay_nxt;

  always_comb begin
    ulx = ul_r[REG_W-1:RAW_W];  uly = ul_r[RAW_W-1:0];
    urx = ur_r[REG_W-1:RAW_W];  ury = ur_r[RAW_W-1:0];
    lrx = lr_r[REG_W-1:RAW_W];  lry = lr_r[RAW_W-1:0];
    llx = ll_r[REG_W-1:RAW_W];  lly = ll_r[RAW_W-1:0];

    d1x = DEN_W'({1'b0, urx}) - DEN_W'({1'b0, ulx});
    d2x = DEN_W'({1'b0, lrx}) - DEN_W'({1'b0, llx});
    d1y = DEN_W'({1'b0, lly}) - DEN_W'({1'b0, uly});
    d2y = DEN_W'({1'b0, lry}) - DEN_W'({1'b0, ury});
    dx  = half14({d1x[DEN_W-1], d1x} + {d2x[DEN_W-1], d2x});
    dy  = half14({d1y[DEN_W-1], d1y} + {d2y[DEN_W-1], d2y});

    spx = SPAN_W'(SCREEN_WIDTH) - SPAN_W'({eo_r, 1'b0});
    spy = SPAN_W'(SCREEN_HEIGHT) - SPAN_W'({eo_r, 1'b0});

    sax = {1'b0, ulx} + {1'b0, urx};
    sbx = {1'b0, llx} + {1'b0, lrx};
    say = {1'b0, uly} + {1'b0, lly};
    sby = {1'b0, ury} + {1'b0, lry};

    case (step_r)
      2'd0:    begin span_sel = spx; sum_sel = sax; dvs_sel = d1x; end
      2'd1:    begin span_sel = spx; sum_sel = sbx; dvs_sel = d2x; end
      2'd2:    begin span_sel = spy; sum_sel = say; dvs_sel = d1y; end
      default: begin span_sel = spy; sum_sel = sby; dvs_sel = d2y; end
    endcase
    op_a    = {{(CNUM_W-SPAN_W){span_sel[SPAN_W-1]}}, span_sel};
    op_b    = {{(CNUM_W-RAW_W-1){1'b0}}, sum_sel};
    num_nxt = op_a * op_b;

    full_sel = step_r[1] ? RES_W'(SCREEN_HEIGHT) : RES_W'(SCREEN_WIDTH);
    cdiff    = V_W'({1'b0, full_sel}) - {div_quo[CNUM_W-1], div_quo};

    ax_nxt.span = spx;
    ax_nxt.dmag = dx[DEN_W-1] ? DVSM_W'(-dx) : DVSM_W'(dx);
    ax_nxt.dneg = dx[DEN_W-1];
    ax_nxt.ofs  = half29({c_r[0][OFS_W-1], c_r[0]} + {c_r[1][OFS_W-1], c_r[1]});
    ax_nxt.err  = (d1x == '0) || (d2x == '0) || (dx == '0);
    ax_nxt.lim  = (hres_r > LIM_MAX) ? LIM_MAX : hres_r;
    ay_nxt.span = spy;
    ay_nxt.dmag = dy[DEN_W-1] ? DVSM_W'(-dy) : DVSM_W'(dy);
    ay_nxt.dneg = dy[DEN_W-1];
    ay_nxt.ofs  = half29({c_r[2][OFS_W-1], c_r[2]} + {c_r[3][OFS_W-1], c_r[3]});
    ay_nxt.err  = (d1y == '0) || (d2y == '0) || (dy == '0);
    ay_nxt.lim  = (vres_r > LIM_MAX) ? LIM_MAX : vres_r;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    start     = 1'b0;
    case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        start     = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = (step_r == 2'd3) ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = ST_LOAD;
      step_nxt  = 2'd0;
      start     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      step_r  <= 2'd0;
      ul_r    <= UL_RST;
      ur_r    <= UR_RST;
      lr_r    <= LR_RST;
      ll_r    <= LL_RST;
      eo_r    <= EO_RST;
      hres_r  <= HR_RST;
      vres_r  <= VR_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_UL:   ul_r   <= cfg_wdata;
          REG_UR:   ur_r   <= cfg_wdata;
          REG_LR:   lr_r   <= cfg_wdata;
          REG_LL:   ll_r   <= cfg_wdata;
          REG_EO:   eo_r   <= cfg_wdata[EO_W-1:0];
          REG_HRES: hres_r <= cfg_wdata[RES_W-1:0];
          REG_VRES: vres_r <= cfg_wdata[RES_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      num_r <= num_nxt;
      dvs_r <= dvs_sel;
    end
    if (state_r == ST_WAIT && div_done) begin
      c_r[step_r] <= half29(cdiff);
    end
    if (state_r == ST_FIN) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
  end

  tfpc_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (num_r),
    .dvs   (dvs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign coef.ax   = ax_r;
  assign coef.ay   = ay_r;
  assign coef.busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/tfpc_axis.sv =====
// ----------------------------------------------------------------------------
// tfpc_axis
// one axis of the sample pipeline: multiply, magnitude, restoring divide
// one bit a stage, add intercept, clamp
// ----------------------------------------------------------------------------
module tfpc_axis
  import tfpc_pkg::*;
(
  input  logic               clk,
  input  logic [NSTG-1:0]    en,
  input  logic [RAW_W-1:0]   raw,
  input  axis_coef_t         cf,
  output logic [COORD_W-1:0] coord
);

  logic signed [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic [DVSM_W-1:0]        rem_r [DIV_STG];
  logic [MAG_W-1:0]         q_r   [DIV_STG];
  logic                     ng_r  [DIV_STG];
  logic signed [V_W-1:0]    v_r;
  logic [COORD_W-1:0]       coord_r;

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [V_W-1:0]    qs;
  logic signed [V_W-1:0]    v_nxt;
  logic [COORD_W-1:0]       coord_nxt;
  logic [RES_W-1:0]         lim_m1;

  always_comb begin
    prod_nxt = $signed({1'b0, raw}) * cf.span;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
    end
    if (en[1]) begin
      mag_r <= prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
      neg_r <= prod_r[PROD_W-1] ^ cf.dneg;
    end
  end

  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    logic [DVSM_W-1:0] rem_in;
    logic [MAG_W-1:0]  q_in;
    logic              ng_in;
    logic [DVSM_W:0]   stp;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = mag_r;
      assign ng_in  = neg_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign ng_in  = ng_r[j-1];
    end
    assign stp = div_step(rem_in, q_in[MAG_W-1], cf.dmag);
    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        rem_r[j] <= stp[DVSM_W-1:0];
        q_r[j]   <= {q_in[MAG_W-2:0], stp[DVSM_W]};
        ng_r[j]  <= ng_in;
      end
    end
  end

  always_comb begin
    qs     = $signed(V_W'(q_r[DIV_STG-1]));
    qs     = ng_r[DIV_STG-1] ? -qs : qs;
    v_nxt  = {cf.ofs[OFS_W-1], cf.ofs} + qs;
    lim_m1 = cf.lim - 1'b1;
    if (cf.err || v_r[V_W-1] || cf.lim == '0) begin
      coord_nxt = '0;
    end else if (v_r >= $signed(V_W'(cf.lim))) begin
      coord_nxt = lim_m1[COORD_W-1:0];
    end else begin
      coord_nxt = v_r[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-2]) begin
      v_r <= v_nxt;
    end
    if (en[NSTG-1]) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

// ===== rtl/touch_four_point_calibrate_scale.sv =====
// ----------------------------------------------------------------------------
// touch_four_point_calibrate_scale
// Maps raw touch samples to clamped screen pixels. The sample pipeline is 28
// stages deep (one multiply stage, a magnitude stage, a 24-stage restoring
// divider, an intercept add and a clamp/output stage) and takes one sample a
// cycle when not stalled; each stage holds its beat when the next one is full
// and stalled, so bubbles close up under output back-pressure. After reset and
// after every configuration write the coefficient unit runs four serial
// divisions, and in_tready stays low until it has finished.
// ----------------------------------------------------------------------------
module touch_four_point_calibrate_scale
  import tfpc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [REG_W-1:0]  in_tdata,   // raw_x, raw_y
  input  logic              in_tuser,   // pressed
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // screen_x, screen_y, zero pad
  output logic [1:0]        out_tuser,  // pressed_out, cal_error
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata
);

  coef_t              coef;
  logic [NSTG-1:0]    vld_r;
  logic [NSTG-1:0]    prs_r;
  logic [NSTG-1:0]    rdy;
  logic [COORD_W-1:0] sx, sy;

  tfpc_coef #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // a stage may load when it is empty or its beat moves on
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_tready = rdy[0] && !coef.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid && in_tready;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prs_r[0] <= in_tuser;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        prs_r[i] <= prs_r[i-1];
      end
    end
  end

  tfpc_axis u_axis_x (
    .clk   (clk),
    .en    (rdy),
    .raw   (in_tdata[RAW_W-1:0]),
    .cf    (coef.ax),
    .coord (sx)
  );

  tfpc_axis u_axis_y (
    .clk   (clk),
    .en    (rdy),
    .raw   (in_tdata[REG_W-1:RAW_W]),
    .cf    (coef.ay),
    .coord (sy)
  );

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {{(OUT_DW-2*COORD_W){1'b0}}, sy, sx};
  assign out_tuser  = {coef.ax.err || coef.ay.err, prs_r[NSTG-1]};

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    coef.busy |-> !in_tready)
    else $error("sample taken while coefficients are being derived");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> coef.busy)
    else $error("register write did not restart the coefficient unit");

  a_err_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && coef.ax.err |-> out_tdata[COORD_W-1:0] == '0)
    else $error("x coordinate not zero with a zero divisor");

  a_clamp_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && coef.ax.lim != '0 |-> RES_W'(out_tdata[COORD_W-1:0]) < coef.ax.lim)
    else $error("x coordinate beyond the clamp limit");

endmodule

// ===== verif/touch_four_point_calibrate_scale_chk.sv =====
// ----------------------------------------------------------------------------
// touch_four_point_calibrate_scale_chk
// Watches the configuration port and both streams of the calibration block.
// It keeps its own copy of the registers and coefficients, works out the
// pixel beat for every accepted sample and compares the outgoing beats in
// order, field by field.
// ----------------------------------------------------------------------------
module touch_four_point_calibrate_scale_chk
  import tfpc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [REG_W-1:0]  in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic [1:0]        out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int  den;
    int  ofs;
    bit  err;
  } axis_cal_t;

  typedef struct {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic               pr;
    logic               er;
  } pixel_t;

  logic [REG_W-1:0] corner [4];
  logic [EO_W-1:0]  edge_ofs;
  logic [RES_W-1:0] hres, vres;
  int               span_x, span_y;
  axis_cal_t        cal_x, cal_y;
  pixel_t           pixel_q[$];

  function automatic axis_cal_t derive(longint full, longint span, longint a0, longint a1,
                                       longint b0, longint b1);
    axis_cal_t r;
    longint d1, d2, d, c1, c2;
    d1 = a1 - a0;
    d2 = b1 - b0;
    d = (d1 + d2) / 2;
    r.den = int'(d);
    if (d1 == 0 || d2 == 0 || d == 0) begin
      r.ofs = 0;
      r.err = 1'b1;
      return r;
    end
    c1 = (full - (span * (a0 + a1)) / d1) / 2;
    c2 = (full - (span * (b0 + b1)) / d2) / 2;
    r.ofs = int'((c1 + c2) / 2);
    r.err = 1'b0;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] map_axis(logic [RAW_W-1:0] raw, axis_cal_t c,
                                                   int span, logic [RES_W-1:0] res);
    longint v, lim;
    if (c.err || c.den == 0) return '0;
    v = longint'(c.ofs) + (longint'(raw) * longint'(span)) / longint'(c.den);
    lim = longint'(res);
    if (lim > 2048) lim = 2048;
    if (v < 0 || lim == 0) return '0;
    if (v >= lim) v = lim - 1;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint rx(logic [REG_W-1:0] v);
    return longint'(v[REG_W-1:RAW_W]);
  endfunction

  function automatic longint ry(logic [REG_W-1:0] v);
    return longint'(v[RAW_W-1:0]);
  endfunction

  task automatic recalc();
    span_x = SCREEN_WIDTH - 2 * int'(edge_ofs);
    span_y = SCREEN_HEIGHT - 2 * int'(edge_ofs);
    cal_x = derive(SCREEN_WIDTH, span_x, rx(corner[REG_UL]), rx(corner[REG_UR]),
                   rx(corner[REG_LL]), rx(corner[REG_LR]));
    cal_y = derive(SCREEN_HEIGHT, span_y, ry(corner[REG_UL]), ry(corner[REG_LL]),
                   ry(corner[REG_UR]), ry(corner[REG_LR]));
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    corner[REG_UL] = UL_RST;
    corner[REG_UR] = UR_RST;
    corner[REG_LR] = LR_RST;
    corner[REG_LL] = LL_RST;
    edge_ofs = EO_RST;
    hres = HR_RST;
    vres = VR_RST;
    recalc();
  end

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    pixel_t e, p;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t unexpected output beat", $time);
          fails++;
        end else begin
          e = pixel_q.pop_front();
          if (out_tdata[COORD_W-1:0] !== e.sx) report("screen_x", out_tdata[COORD_W-1:0], e.sx);
          if (out_tdata[2*COORD_W-1:COORD_W] !== e.sy)
            report("screen_y", out_tdata[2*COORD_W-1:COORD_W], e.sy);
          if (out_tuser[0] !== e.pr) report("pressed_out", out_tuser[0], e.pr);
          if (out_tuser[1] !== e.er) report("cal_error", out_tuser[1], e.er);
        end
      end
      if (in_tvalid && in_tready) begin
        p.sx = map_axis(in_tdata[RAW_W-1:0], cal_x, span_x, hres);
        p.sy = map_axis(in_tdata[REG_W-1:RAW_W], cal_y, span_y, vres);
        p.pr = in_tuser;
        p.er = cal_x.err || cal_y.err;
        pixel_q.push_back(p);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_UL, REG_UR, REG_LR, REG_LL: corner[cfg_addr[1:0]] = cfg_wdata;
          REG_EO:   edge_ofs = cfg_wdata[EO_W-1:0];
          REG_HRES: hres = cfg_wdata[RES_W-1:0];
          REG_VRES: vres = cfg_wdata[RES_W-1:0];
          default: ;
        endcase
        recalc();
      end
    end
  end

endmodule

// ===== verif/touch_four_point_calibrate_scale_tb.sv =====
// ----------------------------------------------------------------------------
// touch_four_point_calibrate_scale_tb
// Drives raw touch samples through the calibration block under a series of
// corner settings (reset values, zero divisors, saturated and mirrored
// readings, extreme edge offsets and resolutions, random layouts), with random
// idling on both streams, one long output hold-off and a gap-free stretch.
// ----------------------------------------------------------------------------
module touch_four_point_calibrate_scale_tb;
  import tfpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam int N_PHASES   = 12;
  localparam int PHASE_LEN  = 145;
  localparam int QUIET_PH   = 6;
  localparam int HOLD_PH    = 3;
  localparam int WDOG_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [REG_W-1:0]  in_tdata = '0;    // raw_x, raw_y
  logic              in_tuser = 1'b0;  // pressed
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;        // screen_x, screen_y, zero pad
  logic [1:0]        out_tuser;        // pressed_out, cal_error
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [REG_W-1:0]  cfg_wdata = '0;
  int                fails, pending;
  int                phase = 0;
  bit                hold = 1'b0;
  int                idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_four_point_calibrate_scale DUT (.*);

  touch_four_point_calibrate_scale_chk chk (.*);

  always @(posedge clk) begin
    out_tready <= !hold && (phase == QUIET_PH || $urandom_range(99) >= 15);
  end

  initial begin
    wait (phase == HOLD_PH);
    repeat (20) @(posedge clk);
    hold = 1'b1;
    repeat (300) @(posedge clk);
    hold = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired in phase %0d", phase);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y, logic p);
    if (phase != QUIET_PH && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tuser <= p;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [REG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pt(int x, int y);
    return {x[RAW_W-1:0], y[RAW_W-1:0]};
  endfunction

  function automatic logic [REG_W-1:0] pick_res();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'd4095;
      2: return REG_W'(LIM_MAX);
      default: return 24'($urandom_range(2048, 1));
    endcase
  endfunction

  task automatic configure(int k);
    int lo, hi, lo2, hi2;
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    lo = $urandom_range(1000);
    hi = $urandom_range(4095, 3000);
    lo2 = $urandom_range(1000);
    hi2 = $urandom_range(4095, 3000);
    case (k)
      0: begin
        write_reg(REG_UL, UL_RST); write_reg(REG_UR, UR_RST);
        write_reg(REG_LR, LR_RST); write_reg(REG_LL, LL_RST);
        write_reg(REG_EO, REG_W'(EO_RST)); write_reg(REG_HRES, REG_W'(HR_RST));
        write_reg(REG_VRES, REG_W'(VR_RST)); write_reg(REG_UNUSED, '1);
      end
      1: begin
        write_reg(REG_UL, '0); write_reg(REG_UR, '0);
        write_reg(REG_LR, '0); write_reg(REG_LL, '0);
        write_reg(REG_EO, '0); write_reg(REG_HRES, '0); write_reg(REG_VRES, '0);
      end
      2: begin
        write_reg(REG_UL, '1); write_reg(REG_UR, '1);
        write_reg(REG_LR, '1); write_reg(REG_LL, '1);
        write_reg(REG_EO, 24'hFF); write_reg(REG_HRES, 24'hFFF); write_reg(REG_VRES, 24'hFFF);
      end
      3: begin
        write_reg(REG_UL, pt(4000, 4050)); write_reg(REG_UR, pt(60, 4010));
        write_reg(REG_LR, pt(90, 30)); write_reg(REG_LL, pt(3990, 70));
        write_reg(REG_EO, 24'hFF); write_reg(REG_HRES, REG_W'(LIM_MAX));
        write_reg(REG_VRES, 24'd1);
      end
      4: begin
        write_reg(REG_UL, pt(lo, lo2)); write_reg(REG_UR, pt(lo, lo2));
        write_reg(REG_LR, pt(lo + 1, hi2)); write_reg(REG_LL, pt(lo, hi2));
        write_reg(REG_EO, 24'd0); write_reg(REG_HRES, 24'd2047);
        write_reg(REG_VRES, REG_W'(LIM_MAX));
      end
      5: begin
        write_reg(REG_UL, pt(lo, lo2)); write_reg(REG_UR, pt(lo + 1, lo2));
        write_reg(REG_LR, pt(lo - 1, hi2)); write_reg(REG_LL, pt(lo, lo2));
        write_reg(REG_EO, 24'd128); write_reg(REG_HRES, pick_res());
        write_reg(REG_VRES, pick_res());
      end
      default: begin
        if ($urandom_range(3) == 0) begin
          write_reg(REG_UL, 24'($urandom)); write_reg(REG_UR, 24'($urandom));
          write_reg(REG_LR, 24'($urandom)); write_reg(REG_LL, 24'($urandom));
        end else begin
          write_reg(REG_UL, pt(lo, lo2));
          write_reg(REG_UR, pt(hi, lo2 + $urandom_range(40)));
          write_reg(REG_LR, pt(hi - $urandom_range(40), hi2));
          write_reg(REG_LL, pt(lo + $urandom_range(40), hi2));
        end
        write_reg(REG_EO, 24'($urandom_range(255)));
        write_reg(REG_HRES, pick_res());
        write_reg(REG_VRES, pick_res());
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic random_sample();
    logic [RAW_W-1:0] x, y;
    x = RAW_W'($urandom);
    y = RAW_W'($urandom);
    if ($urandom_range(9) == 0) x = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(9) == 0) y = $urandom_range(1) ? '1 : '0;
    send(x, y, 1'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send('0, '0, 1'b0);
    send('1, '1, 1'b1);
    send('0, '1, 1'b1);
    send('1, '0, 1'b0);
    send(12'd200, 12'd200, 1'b1);
    send(12'd3900, 12'd3900, 1'b0);
    send(12'd2048, 12'd2048, 1'b1);
    send(12'h555, 12'hAAA, 1'b0);
    send(12'hAAA, 12'h555, 1'b1);
    for (int p = 0; p < N_PHASES; p++) begin
      configure(p);
      phase <= p;
      send('0, '1, 1'b1);
      send('1, '0, 1'b0);
      for (int i = 0; i < PHASE_LEN; i++) random_sample();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d calibration settings incl. zero divisors, mirrored corners,",
             N_PHASES);
    $display("extreme edge offsets and resolutions, with random idling and a long hold-off");
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
